>>> hdl/ldfm_pkg.sv
// Shared types, constants and fixed-point helpers for the lens distortion forward map.
// No dependencies; every module in hdl/ imports this package.
package ldfm_pkg;

    localparam int COORD_W = 12;
    localparam int FRAC_W  = 16;
    localparam int QUO_W   = COORD_W + FRAC_W;
    localparam int DIM_W   = 13;
    localparam int COEF_W  = 20;
    localparam int CTR_W   = 18;
    localparam int FRAME_W = 29;
    localparam int XD_W    = 31 + DIM_W - FRAC_W;
    localparam int DEST_W  = 15;

    typedef logic signed [31:0] q_t;

    typedef enum logic [2:0] {
        REG_K1      = 3'd0,
        REG_K2      = 3'd1,
        REG_K3      = 3'd2,
        REG_P1      = 3'd3,
        REG_P2      = 3'd4,
        REG_CX      = 3'd5,
        REG_CY      = 3'd6,
        REG_FRAME   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pix_t;

    typedef struct packed {
        logic [DIM_W-1:0] r;
        logic [1:0]       q;
    } div2_t;

    localparam q_t ONE_Q16 = 32'sd65536;

    // Two restoring division steps; remainder stays below the divisor.
    function automatic div2_t div_step2(logic [DIM_W-1:0] r, logic [1:0] b,
                                        logic [DIM_W-1:0] d);
        logic [DIM_W:0]   t;
        logic [DIM_W-1:0] rr;
        div2_t            o;
        t = {r, b[1]};
        if (t >= {1'b0, d})
        begin
            rr     = DIM_W'(t - {1'b0, d});
            o.q[1] = 1'b1;
        end
        else
        begin
            rr     = t[DIM_W-1:0];
            o.q[1] = 1'b0;
        end
        t = {rr, b[0]};
        if (t >= {1'b0, d})
        begin
            rr     = DIM_W'(t - {1'b0, d});
            o.q[0] = 1'b1;
        end
        else
        begin
            rr     = t[DIM_W-1:0];
            o.q[0] = 1'b0;
        end
        o.r = rr;
        return o;
    endfunction

    function automatic q_t sat64(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic q_t add_sat(q_t a, q_t b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'sh80000000 : 32'sh7fffffff;
        else
            return s[31:0];
    endfunction

    // Q16 product, truncated toward zero, saturated.
    function automatic q_t mulq(q_t a, q_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        if (p[63])
            p = p + 64'sd65535;
        return sat64(p >>> FRAC_W);
    endfunction

endpackage

>>> hdl/ldfm_norm.sv
// Normalizer: pipelined radix-4 divider for coord*65536/dim, then center subtract.
// Depends on ldfm_pkg.
module ldfm_norm
    import ldfm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [COORD_W-1:0]      src_x,
    input  logic [COORD_W-1:0]      src_y,
    input  pix_t                    in_pix,
    input  logic [DIM_W-1:0]        fw,
    input  logic [DIM_W-1:0]        fh,
    input  logic signed [CTR_W-1:0] cx,
    input  logic signed [CTR_W-1:0] cy,
    output logic                    out_valid,
    output q_t                      xp,
    output q_t                      yp,
    output pix_t                    out_pix
);

    localparam int NS = QUO_W / 2;

    logic [QUO_W-1:0] nx_reg [NS];
    logic [QUO_W-1:0] ny_reg [NS];
    logic [QUO_W-1:0] qx_reg [NS];
    logic [QUO_W-1:0] qy_reg [NS];
    logic [DIM_W-1:0] rx_reg [NS];
    logic [DIM_W-1:0] ry_reg [NS];
    logic             v_reg  [NS];
    pix_t             pix_reg[NS];

    logic             ov_reg;
    q_t               xp_reg;
    q_t               yp_reg;
    pix_t             opix_reg;

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [QUO_W-1:0] nx_in, ny_in, qx_in, qy_in;
        logic [DIM_W-1:0] rx_in, ry_in;
        logic             v_in;
        pix_t             p_in;
        div2_t            dx, dy;

        if (s == 0)
        begin : g_first
            assign nx_in = {src_x, FRAC_W'(0)};
            assign ny_in = {src_y, FRAC_W'(0)};
            assign qx_in = '0;
            assign qy_in = '0;
            assign rx_in = '0;
            assign ry_in = '0;
            assign v_in  = in_valid;
            assign p_in  = in_pix;
        end
        else
        begin : g_next
            assign nx_in = nx_reg[s-1];
            assign ny_in = ny_reg[s-1];
            assign qx_in = qx_reg[s-1];
            assign qy_in = qy_reg[s-1];
            assign rx_in = rx_reg[s-1];
            assign ry_in = ry_reg[s-1];
            assign v_in  = v_reg[s-1];
            assign p_in  = pix_reg[s-1];
        end

        assign dx = div_step2(rx_in, nx_in[QUO_W-1 -: 2], fw);
        assign dy = div_step2(ry_in, ny_in[QUO_W-1 -: 2], fh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nx_reg[s]  <= nx_in << 2;
                ny_reg[s]  <= ny_in << 2;
                qx_reg[s]  <= {qx_in[QUO_W-3:0], dx.q};
                qy_reg[s]  <= {qy_in[QUO_W-3:0], dy.q};
                rx_reg[s]  <= dx.r;
                ry_reg[s]  <= dy.r;
                pix_reg[s] <= p_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= v_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xp_reg   <= q_t'(qx_reg[NS-1]) - 32'(cx);
            yp_reg   <= q_t'(qy_reg[NS-1]) - 32'(cy);
            opix_reg <= pix_reg[NS-1];
        end
    end

    assign out_valid = ov_reg;
    assign xp        = xp_reg;
    assign yp        = yp_reg;
    assign out_pix   = opix_reg;

endmodule

>>> hdl/ldfm_poly.sv
// Distortion polynomial: radial and tangential terms, at most one multiply level per stage.
// Depends on ldfm_pkg.
module ldfm_poly
    import ldfm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  q_t                       xp,
    input  q_t                       yp,
    input  pix_t                     in_pix,
    input  logic signed [COEF_W-1:0] k1,
    input  logic signed [COEF_W-1:0] k2,
    input  logic signed [COEF_W-1:0] k3,
    input  logic signed [COEF_W-1:0] p1,
    input  logic signed [COEF_W-1:0] p2,
    input  q_t                       cxs,
    input  q_t                       cys,
    output logic                     out_valid,
    output q_t                       xc,
    output q_t                       yc,
    output pix_t                     out_pix
);

    localparam int NP = 10;

    logic v_reg  [NP];
    pix_t pix_reg[NP];

    q_t k1q, k2q, k3q, p1q, p2q, p1x2, p2x2;

    // per-stage data
    q_t xp1_reg, yp1_reg, xp2_reg, yp2_reg, xyp_reg;
    q_t xp2s_reg, yp2s_reg, r2_reg, a_reg, b_reg, m1_reg, m4_reg;
    q_t xp3_reg, yp3_reg, r23_reg, sxs_reg, sys_reg, mrk3_reg, m13_reg, m43_reg;
    q_t xp4_reg, yp4_reg, r24_reg, m14_reg, m44_reg, m2_reg, m3_reg, rc_reg;
    q_t xp5_reg, yp5_reg, r25_reg, tx5_reg, ty5_reg, mrc_reg;
    q_t xp6_reg, yp6_reg, r26_reg, tx6_reg, ty6_reg, rc2_reg;
    q_t xp7_reg, yp7_reg, tx7_reg, ty7_reg, m7_reg;
    q_t xp8_reg, yp8_reg, tx8_reg, ty8_reg, rc3_reg;
    q_t tx9_reg, ty9_reg, mx_reg, my_reg;
    q_t xc_reg, yc_reg;

    assign k1q  = 32'(k1);
    assign k2q  = 32'(k2);
    assign k3q  = 32'(k3);
    assign p1q  = 32'(p1);
    assign p2q  = 32'(p2);
    assign p1x2 = p1q <<< 1;
    assign p2x2 = p2q <<< 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NP; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg[0] <= in_pix;
            for (int i = 1; i < NP; i++)
                pix_reg[i] <= pix_reg[i-1];

            // squares and cross term
            xp1_reg  <= xp;
            yp1_reg  <= yp;
            xp2_reg  <= mulq(xp, xp);
            yp2_reg  <= mulq(yp, yp);
            xyp_reg  <= mulq(xp, yp);
            // r^2, doubled squares, tangential cross products
            xp2s_reg <= xp1_reg;
            yp2s_reg <= yp1_reg;
            r2_reg   <= add_sat(xp2_reg, yp2_reg);
            a_reg    <= add_sat(xp2_reg, xp2_reg);
            b_reg    <= add_sat(yp2_reg, yp2_reg);
            m1_reg   <= mulq(p1x2, xyp_reg);
            m4_reg   <= mulq(p2x2, xyp_reg);
            // tangential sums, innermost radial product
            xp3_reg  <= xp2s_reg;
            yp3_reg  <= yp2s_reg;
            r23_reg  <= r2_reg;
            sxs_reg  <= add_sat(r2_reg, a_reg);
            sys_reg  <= add_sat(r2_reg, b_reg);
            mrk3_reg <= mulq(r2_reg, k3q);
            m13_reg  <= m1_reg;
            m43_reg  <= m4_reg;
            // tangential products, radial k2 term
            xp4_reg  <= xp3_reg;
            yp4_reg  <= yp3_reg;
            r24_reg  <= r23_reg;
            m14_reg  <= m13_reg;
            m44_reg  <= m43_reg;
            m2_reg   <= mulq(p2q, sxs_reg);
            m3_reg   <= mulq(p1q, sys_reg);
            rc_reg   <= add_sat(k2q, mrk3_reg);
            // tangential totals, second radial product
            xp5_reg  <= xp4_reg;
            yp5_reg  <= yp4_reg;
            r25_reg  <= r24_reg;
            tx5_reg  <= add_sat(m14_reg, m2_reg);
            ty5_reg  <= add_sat(m3_reg, m44_reg);
            mrc_reg  <= mulq(r24_reg, rc_reg);
            // radial k1 term
            xp6_reg  <= xp5_reg;
            yp6_reg  <= yp5_reg;
            r26_reg  <= r25_reg;
            tx6_reg  <= tx5_reg;
            ty6_reg  <= ty5_reg;
            rc2_reg  <= add_sat(k1q, mrc_reg);
            // third radial product
            xp7_reg  <= xp6_reg;
            yp7_reg  <= yp6_reg;
            tx7_reg  <= tx6_reg;
            ty7_reg  <= ty6_reg;
            m7_reg   <= mulq(r26_reg, rc2_reg);
            // radial factor
            xp8_reg  <= xp7_reg;
            yp8_reg  <= yp7_reg;
            tx8_reg  <= tx7_reg;
            ty8_reg  <= ty7_reg;
            rc3_reg  <= add_sat(ONE_Q16, m7_reg);
            // apply radial factor
            tx9_reg  <= tx8_reg;
            ty9_reg  <= ty8_reg;
            mx_reg   <= mulq(xp8_reg, rc3_reg);
            my_reg   <= mulq(yp8_reg, rc3_reg);
            // add tangential and scaled center
            xc_reg   <= add_sat(add_sat(mx_reg, tx9_reg), cxs);
            yc_reg   <= add_sat(add_sat(my_reg, ty9_reg), cys);
        end
    end

    assign out_valid = v_reg[NP-1];
    assign xc        = xc_reg;
    assign yc        = yc_reg;
    assign out_pix   = pix_reg[NP-1];

endmodule

>>> hdl/lens_distortion_forward_map_core.sv
// Top level of the lens distortion forward map: config registers, final scaling, output.
// Depends on ldfm_pkg, ldfm_norm and ldfm_poly.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one source pixel per item:
//   src_x, src_y and its RGBA. The output channel (out_valid / out_stall)
//   returns one item per input: keep, dest_x, dest_y and the RGBA unchanged.
//   Configuration registers are written through cfg_we / cfg_index / cfg_data
//   while no item is in flight.
// Stages and throughput:
//   27 register stages: 15 in the normalizer (a radix-4 divider of 14
//   stages plus the center subtract), 10 in the polynomial pipeline (at
//   most one multiply level per stage), 2 for destination scaling and
//   the output register. One item per cycle while the output is not stalled.
// Reset:
//   rst_n clears all valid bits and loads the register defaults (zero
//   coefficients, center 0.5, frame 640 x 480).
// Stall:
//   When an item waits in the output register and out_stall is high, the
//   whole pipeline holds and in_stall rises; nothing is dropped or repeated.
module lens_distortion_forward_map_core
    import ldfm_pkg::*;
#(
    parameter int MAX_DIM       = 4096,
    parameter int DEST_SCALE_Q8 = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [FRAME_W-1:0]  cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [COORD_W-1:0]  src_x,
    input  logic [COORD_W-1:0]  src_y,
    input  logic [7:0]          red_in,
    input  logic [7:0]          green_in,
    input  logic [7:0]          blue_in,
    input  logic [7:0]          alpha_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                keep,
    output logic [DEST_W-1:0]   dest_x,
    output logic [DEST_W-1:0]   dest_y,
    output logic [7:0]          red_out,
    output logic [7:0]          green_out,
    output logic [7:0]          blue_out,
    output logic [7:0]          alpha_out
);

    localparam int DS_W  = $clog2(DEST_SCALE_Q8 + 1) + 1;
    localparam int CXM_W = CTR_W + DS_W;
    localparam int WDS_W = DIM_W + DS_W;

    // Configuration registers
    logic signed [COEF_W-1:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;
    logic signed [CTR_W-1:0]  cx_reg, cy_reg;
    logic [FRAME_W-1:0]       frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg    <= '0;
            k2_reg    <= '0;
            k3_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            cx_reg    <= CTR_W'(32768);
            cy_reg    <= CTR_W'(32768);
            frame_reg <= FRAME_W'(31457920);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_K1:    k1_reg    <= cfg_data[COEF_W-1:0];
                REG_K2:    k2_reg    <= cfg_data[COEF_W-1:0];
                REG_K3:    k3_reg    <= cfg_data[COEF_W-1:0];
                REG_P1:    p1_reg    <= cfg_data[COEF_W-1:0];
                REG_P2:    p2_reg    <= cfg_data[COEF_W-1:0];
                REG_CX:    cx_reg    <= cfg_data[CTR_W-1:0];
                REG_CY:    cy_reg    <= cfg_data[CTR_W-1:0];
                REG_FRAME: frame_reg <= cfg_data;
                default:   frame_reg <= frame_reg;
            endcase
        end
    end

    // Clamp a frame dimension: zero reads as one, oversize as MAX_DIM.
    function automatic logic [DIM_W-1:0] dim_of(logic [15:0] raw);
        if (raw == 16'd0)
            return DIM_W'(1);
        else if (raw > 16'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        else
            return raw[DIM_W-1:0];
    endfunction

    logic [DIM_W-1:0]        fw, fh;
    logic signed [CXM_W-1:0] cxm, cym;
    q_t                      cxs, cys;
    logic [WDS_W-1:0]        fwds, fhds;
    logic [XD_W-1:0]         w2, h2;

    assign fw = dim_of(frame_reg[15:0]);
    assign fh = dim_of(16'(frame_reg[FRAME_W-1:16]));

    // Center scaled by the destination scale, truncated toward zero
    assign cxm = CXM_W'(cx_reg) * CXM_W'(DEST_SCALE_Q8);
    assign cym = CXM_W'(cy_reg) * CXM_W'(DEST_SCALE_Q8);
    assign cxs = 32'((cxm + (cxm < 0 ? CXM_W'(255) : CXM_W'(0))) >>> 8);
    assign cys = 32'((cym + (cym < 0 ? CXM_W'(255) : CXM_W'(0))) >>> 8);

    // Destination bounds
    assign fwds = WDS_W'(fw) * WDS_W'(DEST_SCALE_Q8);
    assign fhds = WDS_W'(fh) * WDS_W'(DEST_SCALE_Q8);
    assign w2   = XD_W'(fwds >> 8);
    assign h2   = XD_W'(fhds >> 8);

    // Global advance: hold everything while the output item is stalled
    logic en;
    logic ovalid_reg;

    assign en       = !(ovalid_reg && out_stall);
    assign in_stall = !en;

    pix_t in_pix;
    assign in_pix = '{red: red_in, green: green_in, blue: blue_in, alpha: alpha_in};

    logic norm_valid;
    q_t   xp, yp;
    pix_t norm_pix;

    ldfm_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .src_x     (src_x),
        .src_y     (src_y),
        .in_pix    (in_pix),
        .fw        (fw),
        .fh        (fh),
        .cx        (cx_reg),
        .cy        (cy_reg),
        .out_valid (norm_valid),
        .xp        (xp),
        .yp        (yp),
        .out_pix   (norm_pix)
    );

    logic poly_valid;
    q_t   xc, yc;
    pix_t poly_pix;

    ldfm_poly u_poly
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (norm_valid),
        .xp        (xp),
        .yp        (yp),
        .in_pix    (norm_pix),
        .k1        (k1_reg),
        .k2        (k2_reg),
        .k3        (k3_reg),
        .p1        (p1_reg),
        .p2        (p2_reg),
        .cxs       (cxs),
        .cys       (cys),
        .out_valid (poly_valid),
        .xc        (xc),
        .yc        (yc),
        .out_pix   (poly_pix)
    );

    // Scale stage: destination = coord * dim / 65536 (coord non-negative)
    logic [30+DIM_W:0] px, py;
    logic              sv_reg;
    logic              neg_reg;
    logic [XD_W-1:0]   xd_reg, yd_reg;
    pix_t              spix_reg;

    assign px = (31 + DIM_W)'(xc[30:0]) * (31 + DIM_W)'(fw);
    assign py = (31 + DIM_W)'(yc[30:0]) * (31 + DIM_W)'(fh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= 1'b0;
        else if (en)
            sv_reg <= poly_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg  <= xc[31] | yc[31];
            xd_reg   <= px[30+DIM_W:FRAC_W];
            yd_reg   <= py[30+DIM_W:FRAC_W];
            spix_reg <= poly_pix;
        end
    end

    // Output register: bounds check, zero the coordinates of a dropped pixel
    logic              keep_next;
    logic              keep_reg;
    logic [DEST_W-1:0] dx_reg, dy_reg;
    pix_t              opix_reg;

    assign keep_next = !neg_reg && (xd_reg <= w2) && (yd_reg <= h2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (en)
            ovalid_reg <= sv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            keep_reg <= keep_next;
            dx_reg   <= keep_next ? xd_reg[DEST_W-1:0] : '0;
            dy_reg   <= keep_next ? yd_reg[DEST_W-1:0] : '0;
            opix_reg <= spix_reg;
        end
    end

    assign out_valid = ovalid_reg;
    assign keep      = keep_reg;
    assign dest_x    = dx_reg;
    assign dest_y    = dy_reg;
    assign red_out   = opix_reg.red;
    assign green_out = opix_reg.green;
    assign blue_out  = opix_reg.blue;
    assign alpha_out = opix_reg.alpha;

endmodule

>>> sim/lens_distortion_forward_map_core_tb.sv
// Self-checking testbench for lens_distortion_forward_map_core: directed table then random pixels,
// checked against a fixed-point distortion predictor. Depends on ldfm_pkg and the core RTL.
module lens_distortion_forward_map_core_tb
    import ldfm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM_P   = 4096;
    localparam int SCALE_Q8    = 256;
    localparam int WATCH_LIMIT = 20000;
    localparam int LATENCY     = 27;

    typedef struct {
        logic        keep;
        logic [14:0] dx;
        logic [14:0] dy;
        logic [7:0]  r, g, b, a;
    } pixel_out_t;

    // One directed row: source pixel plus, where obvious, the typed-in result.
    typedef struct {
        logic [11:0] sx, sy;
        logic [7:0]  r, g, b, a;
        bit          fixed;
        logic        keep;
        logic [14:0] dx, dy;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [FRAME_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [11:0] src_x = '0, src_y = '0;
    logic [7:0] red_in = '0, green_in = '0, blue_in = '0, alpha_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic keep;
    logic [DEST_W-1:0] dest_x, dest_y;
    logic [7:0] red_out, green_out, blue_out, alpha_out;

    always #5 clk = ~clk;

    lens_distortion_forward_map_core u_dut (.*);

    // Shadow copy of the register file used by the predictor.
    longint coef_k1, coef_k2, coef_k3, coef_p1, coef_p2, ctr_x, ctr_y;
    logic [28:0] frame_reg;

    pixel_out_t mapped_q[$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0, recv_idle_pct = 0;
    bit  hold_off = 1'b0;
    bit  stim_done = 1'b0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return sat32((a * b) / 65536);
    endfunction

    function automatic longint frame_dim(longint v);
        if (v == 0) return 1;
        if (v > MAX_DIM_P) return MAX_DIM_P;
        return v;
    endfunction

    function automatic longint sext_w(logic [28:0] v, int w);
        longint x;
        x = v & ((64'sd1 << w) - 1);
        if (x[w-1]) x = x - (64'sd1 << w);
        return x;
    endfunction

    // Map one source pixel through the radial/tangential model.
    function automatic pixel_out_t distort_pixel(logic [11:0] sx, logic [11:0] sy,
                                                 logic [7:0] r, logic [7:0] g,
                                                 logic [7:0] b, logic [7:0] a);
        longint fw, fh, xp, yp, xp2, yp2, xyp, r2, tx, ty, rc, xc, yc, xd, yd;
        pixel_out_t o;
        fw  = frame_dim(frame_reg[15:0]);
        fh  = frame_dim(frame_reg[28:16]);
        xp  = sat32((longint'(sx) * 65536) / fw - ctr_x);
        yp  = sat32((longint'(sy) * 65536) / fh - ctr_y);
        xp2 = qmul(xp, xp);
        yp2 = qmul(yp, yp);
        xyp = qmul(xp, yp);
        r2  = sat32(xp2 + yp2);
        tx  = sat32(qmul(2 * coef_p1, xyp) + qmul(coef_p2, sat32(r2 + sat32(xp2 + xp2))));
        ty  = sat32(qmul(coef_p1, sat32(r2 + sat32(yp2 + yp2))) + qmul(2 * coef_p2, xyp));
        rc  = sat32(coef_k2 + qmul(r2, coef_k3));
        rc  = sat32(coef_k1 + qmul(r2, rc));
        rc  = sat32(65536 + qmul(r2, rc));
        xc  = sat32(sat32(qmul(xp, rc) + tx) + (ctr_x * SCALE_Q8) / 256);
        yc  = sat32(sat32(qmul(yp, rc) + ty) + (ctr_y * SCALE_Q8) / 256);
        o.keep = 1'b1;
        xd = 0;
        yd = 0;
        if (xc < 0 || yc < 0)
            o.keep = 1'b0;
        else
        begin
            xd = (xc * fw) / 65536;
            yd = (yc * fh) / 65536;
            if (xd > (fw * SCALE_Q8) / 256 || yd > (fh * SCALE_Q8) / 256)
                o.keep = 1'b0;
        end
        if (!o.keep)
        begin
            xd = 0;
            yd = 0;
        end
        o.dx = xd[14:0];
        o.dy = yd[14:0];
        o.r = r; o.g = g; o.b = b; o.a = a;
        return o;
    endfunction

    // Write one register at a falling edge and mirror it in the shadow copy.
    task automatic write_reg(reg_idx_t idx, logic [28:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_K1:    coef_k1 = sext_w(val, 20);
            REG_K2:    coef_k2 = sext_w(val, 20);
            REG_K3:    coef_k3 = sext_w(val, 20);
            REG_P1:    coef_p1 = sext_w(val, 20);
            REG_P2:    coef_p2 = sext_w(val, 20);
            REG_CX:    ctr_x   = sext_w(val, 18);
            REG_CY:    ctr_y   = sext_w(val, 18);
            REG_FRAME: frame_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [19:0] k1, logic [19:0] k2, logic [19:0] k3,
                           logic [19:0] p1, logic [19:0] p2, logic [17:0] cx,
                           logic [17:0] cy, logic [28:0] fr);
        write_reg(REG_K1, 29'(k1));
        write_reg(REG_K2, 29'(k2));
        write_reg(REG_K3, 29'(k3));
        write_reg(REG_P1, 29'(p1));
        write_reg(REG_P2, 29'(p2));
        write_reg(REG_CX, 29'(cx));
        write_reg(REG_CY, 29'(cy));
        write_reg(REG_FRAME, fr);
    endtask

    // Offer one pixel; hold it until accepted. Expectation is queued on acceptance.
    task automatic send_pixel(logic [11:0] sx, logic [11:0] sy, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b, logic [7:0] a,
                              bit fixed, pixel_out_t typed);
        pixel_out_t e;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        src_x <= sx; src_y <= sy;
        red_in <= r; green_in <= g; blue_in <= b; alpha_in <= a;
        in_valid <= 1'b1;
        e = fixed ? typed : distort_pixel(sx, sy, r, g, b, a);
        do @(posedge clk); while (in_stall);
        mapped_q.push_back(e);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (mapped_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic random_pixels(int n);
        pixel_out_t none;
        logic [11:0] sx, sy, fw, fh;
        fw = 12'(frame_dim(frame_reg[15:0]) > 4095 ? 4095 : frame_dim(frame_reg[15:0]));
        fh = 12'(frame_dim(frame_reg[28:16]) > 4095 ? 4095 : frame_dim(frame_reg[28:16]));
        none = '{default: '0};
        for (int i = 0; i < n; i++)
        begin
            // Mostly pixels inside the frame; some anywhere in the 12-bit range.
            if ($urandom_range(9) < 8)
            begin
                sx = 12'($urandom_range(fw));
                sy = 12'($urandom_range(fh));
            end
            else
            begin
                sx = 12'($urandom);
                sy = 12'($urandom);
            end
            send_pixel(sx, sy, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       1'b0, none);
        end
    endtask

    function automatic logic [19:0] rand_coef(int span);
        int v;
        v = $urandom_range(2 * span) - span;
        return 20'(v);
    endfunction

    // Receiver: random stall, plus a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        pixel_out_t e;
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (mapped_q.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors++;
            end
            else
            begin
                e = mapped_q.pop_front();
                if (keep !== e.keep)
                begin
                    $error("keep: expected %0d actual %0d", e.keep, keep);
                    errors++;
                end
                if (dest_x !== e.dx)
                begin
                    $error("dest_x: expected %0d actual %0d", e.dx, dest_x);
                    errors++;
                end
                if (dest_y !== e.dy)
                begin
                    $error("dest_y: expected %0d actual %0d", e.dy, dest_y);
                    errors++;
                end
                if (red_out !== e.r)
                begin
                    $error("red_out: expected %0d actual %0d", e.r, red_out);
                    errors++;
                end
                if (green_out !== e.g)
                begin
                    $error("green_out: expected %0d actual %0d", e.g, green_out);
                    errors++;
                end
                if (blue_out !== e.b)
                begin
                    $error("blue_out: expected %0d actual %0d", e.b, blue_out);
                    errors++;
                end
                if (alpha_out !== e.a)
                begin
                    $error("alpha_out: expected %0d actual %0d", e.a, alpha_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!stim_done && idle_cycles >= WATCH_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Long receiver hold-off: once an item waits at the output, in_stall must rise.
    task automatic hold_receiver(int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(negedge clk);
        hold_off = 1'b0;
    endtask

    stim_row_t dir_rows[$];

    initial
    begin
        pixel_out_t typed;
        stim_row_t  row;
        coef_k1 = 0; coef_k2 = 0; coef_k3 = 0; coef_p1 = 0; coef_p2 = 0;
        ctr_x = 32768; ctr_y = 32768;
        frame_reg = 29'd31457920;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table at reset values (identity map over 640 x 480).
        // Origin maps to itself, far corner of the 12-bit range is outside.
        dir_rows = '{
            '{12'd0,    12'd0,    8'd0,   8'd0,   8'd0,   8'd0,   1, 1'b1, 15'd0,   15'd0},
            '{12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 8'd255, 1, 1'b0, 15'd0,   15'd0},
            '{12'd320,  12'd240,  8'd1,   8'd2,   8'd3,   8'd4,   0, 1'b0, 15'd0,   15'd0},
            '{12'd639,  12'd479,  8'hAA,  8'h55,  8'hAA,  8'h55,  0, 1'b0, 15'd0,   15'd0},
            '{12'd640,  12'd480,  8'h55,  8'hAA,  8'h55,  8'hAA,  0, 1'b0, 15'd0,   15'd0},
            '{12'd4095, 12'd0,    8'h80,  8'h01,  8'hFE,  8'h7F,  1, 1'b0, 15'd0,   15'd0},
            '{12'd0,    12'd4095, 8'h0F,  8'hF0,  8'h3C,  8'hC3,  1, 1'b0, 15'd0,   15'd0},
            '{12'd2730, 12'd1365, 8'd9,   8'd8,   8'd7,   8'd6,   0, 1'b0, 15'd0,   15'd0}
        };
        for (int i = 0; i < dir_rows.size(); i++)
        begin
            row = dir_rows[i];
            typed = '{row.keep, row.dx, row.dy, row.r, row.g, row.b, row.a};
            send_pixel(row.sx, row.sy, row.r, row.g, row.b, row.a, row.fixed, typed);
        end
        drain();

        // Extreme coefficients, centers and frame sizes (including zero and oversize dims).
        set_all(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF,
                18'h1FFFF, 18'h1FFFF, {13'd4096, 16'd4096});
        for (int i = 0; i < 6; i++)
            send_pixel(12'(i * 819), 12'(4095 - i * 819), 8'(i), 8'(i), 8'(i), 8'(i),
                       1'b0, typed);
        drain();
        set_all(20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000,
                18'h20000, 18'h20000, {13'd0, 16'd0});
        for (int i = 0; i < 5; i++)
            send_pixel(12'(i), 12'(i * 1000), 8'd0, 8'd255, 8'd0, 8'd255, 1'b0, typed);
        drain();
        set_all(20'd6554, 20'd0, 20'd0, 20'd0, 20'd0, 18'd0, 18'd0,
                {13'h1FFF, 16'hFFFF});
        for (int i = 0; i < 5; i++)
            send_pixel(12'(i * 1023), 12'(i * 511), 8'd1, 8'd2, 8'd4, 8'd8, 1'b0, typed);
        drain();

        // Random phases: sender-light / receiver-heavy idling first, then swapped, then none.
        for (int phase = 0; phase < 9; phase++)
        begin
            set_all(rand_coef(phase % 3 == 0 ? 524287 : 20000), rand_coef(20000),
                    rand_coef(8000), rand_coef(3000), rand_coef(3000),
                    18'(32768 + int'($urandom_range(8000)) - 4000),
                    18'(32768 + int'($urandom_range(8000)) - 4000),
                    {13'($urandom_range(4096, 1)), 16'($urandom_range(4096, 1))});
            send_idle_pct = (phase < 3) ? 9 : (phase < 6) ? 78 : 0;
            recv_idle_pct = (phase < 3) ? 78 : (phase < 6) ? 9 : 0;
            if (phase == 6)
            begin
                fork
                    hold_receiver(200);
                    random_pixels(100);
                join
            end
            else
                random_pixels(100);
            drain();
        end

        stim_done = 1'b1;
        if (errors == 0 && mapped_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> filelist.f
hdl/ldfm_pkg.sv
hdl/ldfm_norm.sv
hdl/ldfm_poly.sv
hdl/lens_distortion_forward_map_core.sv
sim/lens_distortion_forward_map_core_tb.sv
